@@ design/upstream_health_selector_unit_macros.svh @@
// Assertion macros for the upstream health selector.
// Used by upstream_health_selector_unit; clocked on clk_i, reset by rst_ni.
`ifndef UPSTREAM_HEALTH_SELECTOR_UNIT_MACROS_SVH
`define UPSTREAM_HEALTH_SELECTOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property outside of reset.
`define UHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property at every edge, reset included.
`define UHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define UHS_ASSERT(lbl, prop, msg)
`define UHS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/uhs_pkg.sv @@
// Types and constants for the upstream health selector.
// No dependencies; imported by upstream_health_selector_unit.
`default_nettype none
package uhs_pkg;

  // Request kinds
  localparam logic [1:0] KIND_SELECT  = 2'd0;
  localparam logic [1:0] KIND_FAILURE = 2'd1;
  localparam logic [1:0] KIND_SUCCESS = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_ERROR_TIMEOUT  = 3'd0;
  localparam logic [2:0] CFG_REVIVE_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_ERR_LIMIT      = 3'd2;
  localparam logic [2:0] CFG_SELECT_MODE    = 3'd3;
  localparam logic [2:0] CFG_ENTRY_COUNT    = 3'd4;
  localparam logic [2:0] CFG_PRIORITIES     = 3'd5;

  // Configuration reset values
  localparam logic [31:0] RST_ERROR_TIMEOUT  = 32'd10;
  localparam logic [31:0] RST_REVIVE_TIMEOUT = 32'd60;
  localparam logic [7:0]  RST_ERR_LIMIT      = 8'd10;
  localparam logic        RST_SELECT_MODE    = 1'b0;
  localparam logic [3:0]  RST_ENTRY_COUNT    = 4'd8;
  localparam logic [63:0] RST_PRIORITIES     = 64'h0101_0101_0101_0101;

  localparam logic        MODE_ROUND_ROBIN = 1'b0;
  localparam logic [7:0]  ERR_COUNT_MAX    = 8'hFF;
  localparam logic [15:0] WEIGHT_MIN       = 16'h8000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  entry_index;
    logic [31:0] now;
  } uhs_req_t;

  typedef struct packed {
    logic [2:0]         selected_index;
    logic signed [15:0] selected_weight;
  } uhs_res_t;

endpackage
`default_nettype wire

@@ design/upstream_health_selector_unit.sv @@
// Channel    | Ports                              | Handshake
// request    | req_i                              | start high while busy low
// result     | res_o                              | res_valid_o, one cycle, no stall
// config     | cfg_we_i, cfg_idx_i, cfg_wdata_i   | write when cfg_we_i high
//
// A failure or success report updates its entry. A select scans the entries in
// use, revives all if every entry is dead, then picks; in round robin, if no
// weight is positive, it reloads weights from priorities and picks again. One
// 32-bit subtract serves the scan and one 16-bit signed compare serves pick and
// reload, one entry per cycle. Reset is asynchronous; the table clears at once.
// The result is shown for one cycle and the receiver cannot hold it.
//
// Health and weight table for a small set of servers with selection logic.
// Depends on uhs_pkg and upstream_health_selector_unit_macros.svh.
`default_nettype none
`include "upstream_health_selector_unit_macros.svh"
module upstream_health_selector_unit
  import uhs_pkg::*;
#(
  parameter int MAX_ENTRIES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire uhs_req_t    req_i,
  output logic             res_valid_o,
  output uhs_res_t         res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = (CW > 3) ? CW : 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPORT,
    ST_SCAN,
    ST_REVIVE,
    ST_PICK,
    ST_RELOAD
  } state_e;

  // Configuration
  logic [31:0] err_timeout_q;
  logic [31:0] rev_timeout_q;
  logic [7:0]  err_limit_q;
  logic        mode_q;
  logic [3:0]  entry_count_q;
  logic [63:0] prio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_timeout_q <= RST_ERROR_TIMEOUT;
      rev_timeout_q <= RST_REVIVE_TIMEOUT;
      err_limit_q   <= RST_ERR_LIMIT;
      mode_q        <= RST_SELECT_MODE;
      entry_count_q <= RST_ENTRY_COUNT;
      prio_q        <= RST_PRIORITIES;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ERROR_TIMEOUT:  err_timeout_q <= cfg_wdata_i[31:0];
        CFG_REVIVE_TIMEOUT: rev_timeout_q <= cfg_wdata_i[31:0];
        CFG_ERR_LIMIT:      err_limit_q   <= cfg_wdata_i[7:0];
        CFG_SELECT_MODE:    mode_q        <= cfg_wdata_i[0];
        CFG_ENTRY_COUNT:    entry_count_q <= cfg_wdata_i[3:0];
        CFG_PRIORITIES:     prio_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Entry table
  logic                dead_q   [MAX_ENTRIES];
  logic [7:0]          err_q    [MAX_ENTRIES];
  logic [31:0]         stamp_q  [MAX_ENTRIES];
  logic signed [15:0]  wgt_q    [MAX_ENTRIES];

  // Sequencer state
  state_e             state_q;
  logic [PW-1:0]      ptr_q;
  logic               is_fail_q;
  logic [31:0]        now_q;
  logic               any_alive_q;
  logic signed [15:0] best_q;
  logic [PW-1:0]      sel_q;
  logic               res_valid_q;
  uhs_res_t           res_q;

  logic [PW-1:0]      n_used;
  logic [IW-1:0]      idx;
  logic               in_range;
  logic               cur_dead;
  logic [7:0]         cur_err;
  logic [31:0]        cur_stamp;
  logic signed [15:0] cur_wgt;
  logic [7:0]         cur_prio;
  logic [31:0]        elapsed;
  logic signed [15:0] cand;
  logic               take;

  logic               tbl_we;
  logic               dead_d;
  logic [7:0]         err_d;
  logic [31:0]        stamp_d;
  logic signed [15:0] wgt_d;

  always_comb begin
    if (32'(entry_count_q) > 32'(MAX_ENTRIES)) begin
      n_used = PW'(MAX_ENTRIES);
    end else begin
      n_used = PW'(entry_count_q);
    end
  end

  assign idx       = ptr_q[IW-1:0];
  assign in_range  = ptr_q < n_used;
  assign cur_dead  = dead_q[idx];
  assign cur_err   = err_q[idx];
  assign cur_stamp = stamp_q[idx];
  assign cur_wgt   = wgt_q[idx];
  // Entries past the eighth have no priority byte.
  assign cur_prio  = (32'(ptr_q) < 32'd8) ? prio_q[{ptr_q[2:0], 3'b000} +: 8] : 8'd0;
  assign elapsed   = now_q - cur_stamp;

  assign cand = (state_q == ST_RELOAD || mode_q != MODE_ROUND_ROBIN)
                ? $signed({8'd0, cur_prio}) : cur_wgt;
  assign take = in_range && !cur_dead && (cand > best_q);

  always_comb begin
    tbl_we  = 1'b0;
    dead_d  = cur_dead;
    err_d   = cur_err;
    stamp_d = cur_stamp;
    wgt_d   = cur_wgt;
    case (state_q)
      ST_REPORT: begin
        tbl_we = 1'b1;
        if (is_fail_q) begin
          if (cur_err == 8'd0 && !cur_dead) begin
            stamp_d = now_q;
          end
          if (cur_err != ERR_COUNT_MAX) begin
            err_d = cur_err + 8'd1;
          end
        end else begin
          if (cur_err != 8'd0) begin
            err_d   = 8'd0;
            stamp_d = 32'd0;
          end
          if (cur_wgt != $signed(WEIGHT_MIN)) begin
            wgt_d = cur_wgt - 16'sd1;
          end
        end
      end
      ST_SCAN: begin
        if (in_range) begin
          tbl_we = 1'b1;
          if (cur_dead) begin
            if (elapsed >= rev_timeout_q) begin
              dead_d  = 1'b0;
              err_d   = 8'd0;
              stamp_d = 32'd0;
              wgt_d   = $signed({8'd0, cur_prio});
            end
          end else if (elapsed >= err_timeout_q && cur_err >= err_limit_q) begin
            dead_d  = 1'b1;
            stamp_d = now_q;
            wgt_d   = 16'sd0;
          end
        end
      end
      ST_REVIVE: begin
        if (in_range) begin
          tbl_we  = 1'b1;
          dead_d  = 1'b0;
          err_d   = 8'd0;
          stamp_d = 32'd0;
          wgt_d   = $signed({8'd0, cur_prio});
        end
      end
      ST_RELOAD: begin
        if (in_range) begin
          tbl_we = 1'b1;
          wgt_d  = $signed({8'd0, cur_prio});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        dead_q[i]  <= 1'b0;
        err_q[i]   <= 8'd0;
        stamp_q[i] <= 32'd0;
        wgt_q[i]   <= 16'sd0;
      end
    end else if (tbl_we) begin
      dead_q[idx]  <= dead_d;
      err_q[idx]   <= err_d;
      stamp_q[idx] <= stamp_d;
      wgt_q[idx]   <= wgt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      is_fail_q   <= 1'b0;
      now_q       <= 32'd0;
      any_alive_q <= 1'b0;
      best_q      <= 16'sd0;
      sel_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            case (req_i.kind)
              KIND_SELECT: begin
                now_q       <= req_i.now;
                ptr_q       <= '0;
                any_alive_q <= 1'b0;
                state_q     <= ST_SCAN;
              end
              KIND_FAILURE, KIND_SUCCESS: begin
                // Drop reports aimed past the table.
                if (32'(req_i.entry_index) < 32'(MAX_ENTRIES)) begin
                  now_q     <= req_i.now;
                  ptr_q     <= PW'(req_i.entry_index);
                  is_fail_q <= (req_i.kind == KIND_FAILURE);
                  state_q   <= ST_REPORT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_REPORT: begin
          state_q <= ST_IDLE;
        end
        ST_SCAN: begin
          if (in_range) begin
            any_alive_q <= any_alive_q | !dead_d;
            ptr_q       <= ptr_q + PW'(1);
          end else begin
            ptr_q   <= '0;
            best_q  <= 16'sd0;
            sel_q   <= '0;
            state_q <= any_alive_q ? ST_PICK : ST_REVIVE;
          end
        end
        ST_REVIVE: begin
          if (in_range) begin
            ptr_q <= ptr_q + PW'(1);
          end else begin
            ptr_q   <= '0;
            state_q <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (in_range) begin
            if (take) begin
              best_q <= cand;
              sel_q  <= ptr_q;
            end
            ptr_q <= ptr_q + PW'(1);
          end else if (mode_q == MODE_ROUND_ROBIN && best_q == 16'sd0) begin
            // No positive weight: reload from priorities and pick again.
            ptr_q   <= '0;
            state_q <= ST_RELOAD;
          end else begin
            res_valid_q          <= 1'b1;
            res_q.selected_index  <= sel_q[2:0];
            res_q.selected_weight <= best_q;
            state_q              <= ST_IDLE;
          end
        end
        ST_RELOAD: begin
          if (in_range) begin
            if (take) begin
              best_q <= cand;
              sel_q  <= ptr_q;
            end
            ptr_q <= ptr_q + PW'(1);
          end else begin
            res_valid_q          <= 1'b1;
            res_q.selected_index  <= sel_q[2:0];
            res_q.selected_weight <= best_q;
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `UHS_ASSERT(a_result_after_work, res_valid_o |-> $past(busy), "result without prior work")
  `UHS_ASSERT(a_sel_busy, start && !busy && req_i.kind == KIND_SELECT |=> busy, "select dropped")
  `UHS_ASSERT(a_single_strobe, res_valid_o |=> !res_valid_o, "result strobe held two cycles")
  `UHS_ASSERT_ALWAYS(a_wgt_pos, res_valid_o |-> !res_o.selected_weight[15], "negative weight")

endmodule
`default_nettype wire
